// ===== sv/lrs_pkg.sv =====
// Shared types and constants for the rim-lit sample shader.
// No dependencies; every other file refers to this package by scoped names.
package lrs_pkg;

    localparam int VEC_FRAC_BITS   = 14;
    localparam int COLOR_FRAC_BITS = 12;
    localparam int DIFF_FRAC_BITS  = 14;
    localparam int OM_SHIFT        = 2 * VEC_FRAC_BITS - 16;
    localparam int EDGE_SHIFT      = 32 - COLOR_FRAC_BITS;

    localparam logic signed [33:0] DOT_ONE = 34'sd1 <<< (2 * VEC_FRAC_BITS);
    localparam logic [19:0] SUM_WHITE = 20'd1 << COLOR_FRAC_BITS;
    localparam logic [16:0] Q16_ONE   = 17'h10000;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_LIT    = 2'd1;

    localparam logic [1:0] CFG_HUE  = 2'd0;
    localparam logic [1:0] CFG_BASE = 2'd1;
    localparam logic [1:0] CFG_RIM  = 2'd2;
    localparam logic [1:0] CFG_LIT  = 2'd3;

    localparam logic [15:0] HUE_RESET  = 16'd38011;
    localparam logic [16:0] BASE_RESET = 17'd52429;
    localparam logic [16:0] RIM_RESET  = 17'd19661;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic [15:0]        red;
        logic [15:0]        green;
        logic [15:0]        blue;
        logic [14:0]        diffuse;
        logic               last;
    } sample_t;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
    } shade_t;

    typedef struct packed {
        logic [15:0] hue;
        logic [16:0] base;
        logic [16:0] rim;
        logic        lit;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_LIGHT,
        OP_SKIP
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             seed_white;
        logic             last;
        logic [2:0][15:0] n;
        logic [2:0][15:0] v;
        logic [2:0][15:0] color;
        logic [14:0]      diffuse;
    } work_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOT,
        ST_SQ,
        ST_EDGE,
        ST_LIGHT,
        ST_HSV,
        ST_MIX,
        ST_PUSH
    } state_t;

endpackage

// ===== sv/lrs_front.sv =====
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on lrs_pkg.
module lrs_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            lit,
    input  logic            sample_valid,
    output logic            sample_stall,
    input  lrs_pkg::sample_t sample,
    output logic            work_valid,
    input  logic            work_pop,
    output lrs_pkg::work_t  work
);

    lrs_pkg::work_t entry_reg [2];
    lrs_pkg::work_t entry_in;
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push, pop;

    always_comb
    begin
        entry_in.seed_white = !lit;
        entry_in.last       = sample.last;
        entry_in.n          = {sample.nz, sample.ny, sample.nx};
        entry_in.v          = {sample.vz, sample.vy, sample.vx};
        entry_in.color      = {sample.blue, sample.green, sample.red};
        entry_in.diffuse    = sample.diffuse;
        priority if (sample.cmd == lrs_pkg::CMD_SAMPLE)
            entry_in.op = lrs_pkg::OP_SAMPLE;
        else if (sample.cmd == lrs_pkg::CMD_LIT && lit)
            entry_in.op = lrs_pkg::OP_LIGHT;
        else
            entry_in.op = lrs_pkg::OP_SKIP;
    end

    assign sample_stall = (count_reg == 2'd2);
    assign work_valid   = (count_reg != 2'd0);
    assign work         = entry_reg[rd_ptr_reg];
    assign push         = sample_valid && !sample_stall;
    assign pop          = work_pop && work_valid;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= entry_in;
    end

endmodule

// ===== sv/lrs_back.sv =====
// Back end: sequencer around one shared multiplier, light sum and rim state, result register.
// Depends on lrs_pkg; fed by lrs_front.
module lrs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  lrs_pkg::cfg_t  cfg,
    input  logic           work_valid,
    output logic           work_pop,
    input  lrs_pkg::work_t work,
    output logic           shade_valid,
    input  logic           shade_stall,
    output lrs_pkg::shade_t shade
);

    lrs_pkg::state_t   state_reg, state_next;
    logic [1:0]        step_reg, step_next;
    lrs_pkg::work_t    item_reg, item_next;
    logic signed [33:0] acc_reg, acc_next;
    logic [16:0]       sq_reg, sq_next;
    logic [15:0]       edge_reg, edge_next;
    logic [2:0][19:0]  sum_reg, sum_next;
    logic [16:0]       qt_reg, qt_next;
    logic [2:0][15:0]  res_reg, res_next;
    logic              shade_valid_reg, shade_valid_next;
    lrs_pkg::shade_t   shade_reg, shade_next;

    logic signed [20:0] mul_a, mul_b;
    logic signed [41:0] prod;

    logic [28:0]       om;
    logic [16:0]       om16;
    logic [18:0]       h6;
    logic [2:0]        sector;
    logic [16:0]       frac;
    logic [17:0]       frac3;
    logic [16:0]       factor;
    logic [16:0]       p_col;
    logic [2:0][16:0]  cols;
    logic [16:0]       chan_col;
    logic [15:0]       nsel, vsel;
    logic [16:0]       light_add;
    logic [20:0]       sum_add;
    logic [21:0]       edge_wide;
    logic [21:0]       mix;
    logic              last_step;

    assign prod = mul_a * mul_b;

    // facing = -dot clamped to 0..1, om = 1 - facing
    always_comb
    begin
        priority if (acc_reg > 34'sd0)
            om = 29'(lrs_pkg::DOT_ONE);
        else if (acc_reg < -lrs_pkg::DOT_ONE)
            om = '0;
        else
            om = 29'(lrs_pkg::DOT_ONE + acc_reg);
        om16 = 17'(om >> lrs_pkg::OM_SHIFT);
    end

    // HSV with saturation 0.75: one of q or t per sector, selected by sector parity
    always_comb
    begin
        h6     = {3'b0, cfg.hue} * 19'd6;
        sector = h6[18:16];
        frac   = sector[0] ? {1'b0, h6[15:0]} : (lrs_pkg::Q16_ONE - {1'b0, h6[15:0]});
        frac3  = {1'b0, frac} + {frac, 1'b0};
        factor = lrs_pkg::Q16_ONE - 17'(frac3 >> 2);
        p_col  = {2'b0, cfg.base[16:2]};
        unique case (sector)
            3'd0:    cols = {p_col, qt_reg, cfg.base};
            3'd1:    cols = {p_col, cfg.base, qt_reg};
            3'd2:    cols = {qt_reg, cfg.base, p_col};
            3'd3:    cols = {cfg.base, qt_reg, p_col};
            3'd4:    cols = {cfg.base, p_col, qt_reg};
            default: cols = {qt_reg, p_col, cfg.base};
        endcase
        chan_col = cols[step_reg];
    end

    assign nsel      = item_reg.n[step_reg];
    assign vsel      = item_reg.v[step_reg];
    assign last_step = (step_reg == 2'd2);

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        item_next        = item_reg;
        acc_next         = acc_reg;
        sq_next          = sq_reg;
        edge_next        = edge_reg;
        sum_next         = sum_reg;
        qt_next          = qt_reg;
        res_next         = res_reg;
        shade_valid_next = shade_valid_reg && shade_stall;
        shade_next       = shade_reg;
        work_pop         = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        light_add        = 17'(prod >> lrs_pkg::DIFF_FRAC_BITS);
        sum_add          = {1'b0, sum_reg[step_reg]} + {4'b0, light_add};
        edge_wide        = 22'(prod >> lrs_pkg::EDGE_SHIFT);
        mix              = {1'b0, 21'(prod >> 16)} + {6'b0, edge_reg};

        unique case (state_reg)
            lrs_pkg::ST_IDLE:
            begin
                if (work_valid)
                begin
                    work_pop  = 1'b1;
                    item_next = work;
                    step_next = 2'd0;
                    unique case (work.op)
                        lrs_pkg::OP_SAMPLE:
                        begin
                            acc_next   = '0;
                            state_next = lrs_pkg::ST_DOT;
                            for (int c = 0; c < 3; c++)
                            begin
                                sum_next[c] = work.seed_white ? lrs_pkg::SUM_WHITE
                                                              : {4'b0, work.color[c]};
                            end
                        end
                        lrs_pkg::OP_LIGHT:
                            state_next = lrs_pkg::ST_LIGHT;
                        lrs_pkg::OP_SKIP:
                            state_next = work.last ? lrs_pkg::ST_HSV : lrs_pkg::ST_IDLE;
                    endcase
                end
            end
            lrs_pkg::ST_DOT:
            begin
                mul_a    = {{5{nsel[15]}}, nsel};
                mul_b    = {{5{vsel[15]}}, vsel};
                acc_next = acc_reg + $signed(prod[33:0]);
                if (last_step)
                begin
                    step_next  = 2'd0;
                    state_next = lrs_pkg::ST_SQ;
                end
                else
                    step_next = step_reg + 2'd1;
            end
            lrs_pkg::ST_SQ:
            begin
                mul_a      = {4'b0, om16};
                mul_b      = {4'b0, om16};
                sq_next    = prod[32:16];
                state_next = lrs_pkg::ST_EDGE;
            end
            lrs_pkg::ST_EDGE:
            begin
                mul_a      = {4'b0, sq_reg};
                mul_b      = {4'b0, cfg.rim};
                edge_next  = (|edge_wide[21:16]) ? 16'hFFFF : edge_wide[15:0];
                state_next = item_reg.last ? lrs_pkg::ST_HSV : lrs_pkg::ST_IDLE;
            end
            lrs_pkg::ST_LIGHT:
            begin
                mul_a              = {6'b0, item_reg.diffuse};
                mul_b              = {5'b0, item_reg.color[step_reg]};
                sum_next[step_reg] = sum_add[20] ? 20'hFFFFF : sum_add[19:0];
                if (last_step)
                begin
                    step_next  = 2'd0;
                    state_next = item_reg.last ? lrs_pkg::ST_HSV : lrs_pkg::ST_IDLE;
                end
                else
                    step_next = step_reg + 2'd1;
            end
            lrs_pkg::ST_HSV:
            begin
                mul_a      = {4'b0, cfg.base};
                mul_b      = {4'b0, factor};
                qt_next    = prod[32:16];
                step_next  = 2'd0;
                state_next = lrs_pkg::ST_MIX;
            end
            lrs_pkg::ST_MIX:
            begin
                mul_a              = {4'b0, chan_col};
                mul_b              = {1'b0, sum_reg[step_reg]};
                res_next[step_reg] = (|mix[21:16]) ? 16'hFFFF : mix[15:0];
                if (last_step)
                begin
                    step_next  = 2'd0;
                    state_next = lrs_pkg::ST_PUSH;
                end
                else
                    step_next = step_reg + 2'd1;
            end
            lrs_pkg::ST_PUSH:
            begin
                if (!shade_valid_reg || !shade_stall)
                begin
                    shade_valid_next     = 1'b1;
                    shade_next.out_red   = res_reg[0];
                    shade_next.out_green = res_reg[1];
                    shade_next.out_blue  = res_reg[2];
                    state_next           = lrs_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lrs_pkg::ST_IDLE;
            step_reg        <= 2'd0;
            shade_valid_reg <= 1'b0;
            sum_reg         <= '0;
            edge_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            shade_valid_reg <= shade_valid_next;
            sum_reg         <= sum_next;
            edge_reg        <= edge_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        acc_reg   <= acc_next;
        sq_reg    <= sq_next;
        qt_reg    <= qt_next;
        res_reg   <= res_next;
        shade_reg <= shade_next;
    end

    assign shade_valid = shade_valid_reg;
    assign shade       = shade_reg;

endmodule

// ===== sv/lit_rim_sample_shader.sv =====
// Top level of the rim-lit sample shader: configuration registers, front queue, back sequencer.
// Depends on lrs_pkg, lrs_front and lrs_back.
//
//   channel   handshake              payload
//   sample    sample_valid/stall     sample (lrs_pkg::sample_t)
//   shade     shade_valid/stall      shade  (lrs_pkg::shade_t)
//   cfg       cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One shared multiplier sets the rate: a sample request runs dot, square and edge steps, a lit
// light a light step per channel, other requests only idle; a last request adds the hue term,
// channel mixes, result load. A two-entry queue lets requests enter while the back end works.
// Reset clears the queue, the sequencer, light sum and rim term, and loads register defaults.
// A stalled result holds in the output register; the back end waits on it only at load.
module lit_rim_sample_shader (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  lrs_pkg::sample_t sample,
    output logic             shade_valid,
    input  logic             shade_stall,
    output lrs_pkg::shade_t  shade,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [16:0]      cfg_data
);

    lrs_pkg::cfg_t  cfg_reg, cfg_next;
    logic           work_valid;
    logic           work_pop;
    lrs_pkg::work_t work;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                lrs_pkg::CFG_HUE:  cfg_next.hue  = cfg_data[15:0];
                lrs_pkg::CFG_BASE: cfg_next.base = cfg_data;
                lrs_pkg::CFG_RIM:  cfg_next.rim  = cfg_data;
                lrs_pkg::CFG_LIT:  cfg_next.lit  = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hue  <= lrs_pkg::HUE_RESET;
            cfg_reg.base <= lrs_pkg::BASE_RESET;
            cfg_reg.rim  <= lrs_pkg::RIM_RESET;
            cfg_reg.lit  <= 1'b1;
        end
        else
            cfg_reg <= cfg_next;
    end

    lrs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .lit          (cfg_reg.lit),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .work_valid   (work_valid),
        .work_pop     (work_pop),
        .work         (work)
    );

    lrs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .work_valid  (work_valid),
        .work_pop    (work_pop),
        .work        (work),
        .shade_valid (shade_valid),
        .shade_stall (shade_stall),
        .shade       (shade)
    );

endmodule
